[sv/bsvp_pkg.sv]
package bsvp_pkg;

    // Field widths of the request and result transactions.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int DEPTH_W  = 9;

    // Defaults for the top-level parameters.
    localparam int DEF_DEPTH     = 256;
    localparam int DEF_WORD_BITS = 32;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PURGE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

[sv/bsvp_mem.sv]
module bsvp_mem import bsvp_pkg::*; #(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [WORD_BITS-1:0]         i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [WORD_BITS-1:0]         o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[sv/bounded_stack_with_value_purge_top.sv]
// Bounded LIFO stack of signed words with a remove-all-equal action.
// Request channel: i_valid / o_stall with i_action and i_value. A transaction
// is taken when i_valid is high and o_stall is low. Result channel: o_valid /
// i_stall with o_status, o_data and o_depth; exactly one result per request.
// The block works on one request at a time and holds o_stall high until the
// result has been placed in the output register. A push, a clear, an empty-stack
// error or an unused code goes through the execute and done states; pop and
// peek add a read state between them for one registered memory read; remove
// adds a purge state that walks every entry through the single read port and
// compacts survivors through the single write port, one entry per cycle.
// The next request can be taken once the block is back in idle, after the
// result has been loaded.
// A new request may be accepted while a finished result still waits in the
// output register; if the receiver keeps i_stall high, the next result waits
// in its final state until the output register frees up, and results are
// never dropped or reordered. Reset clears the entry count and all control
// state; the memory contents are not cleared and are never read before they
// are written.
module bounded_stack_with_value_purge_top import bsvp_pkg::*; #(
    parameter int DEPTH     = DEF_DEPTH,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_data,
    output logic [DEPTH_W-1:0]         o_depth
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_PURGE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state,     n_state;
    logic [CW-1:0]        r_count,     n_count;
    logic [CW-1:0]        r_rd,        n_rd;
    logic [CW-1:0]        r_wr,        n_wr;
    logic                 r_pend,      n_pend;
    logic                 r_out_valid, n_out_valid;
    logic [ACTION_W-1:0]  r_act,       n_act;
    logic [WORD_BITS-1:0] r_word,      n_word;
    logic [STATUS_W-1:0]  r_res_st,    n_res_st;
    logic [DATA_W-1:0]    r_res_dat,   n_res_dat;
    logic [STATUS_W-1:0]  r_o_status,  n_o_status;
    logic [DATA_W-1:0]    r_o_data,    n_o_data;
    logic [DEPTH_W-1:0]   r_o_depth,   n_o_depth;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_q;
    logic [CW-1:0]        w_top;
    logic                 w_issue;

    bsvp_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_top   = CW'(r_count - 1'b1);
    assign w_issue = (r_rd < r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_stall;
        n_act       = r_act;
        n_word      = r_word;
        n_res_st    = r_res_st;
        n_res_dat   = r_res_dat;
        n_o_status  = r_o_status;
        n_o_data    = r_o_data;
        n_o_depth   = r_o_depth;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = r_word;
        w_re        = 1'b0;
        w_raddr     = w_top[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act   = i_action;
                    n_word  = WORD_BITS'($unsigned(i_value));
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_st  = ST_OK;
                n_res_dat = '0;
                n_state   = S_DONE;
                case (r_act)
                    ACT_PUSH: begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_res_st = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = CW'(r_count + 1'b1);
                        end
                    end
                    ACT_POP, ACT_PEEK: begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            w_re    = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    ACT_CLEAR: begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            n_count = '0;
                        end
                    end
                    ACT_PURGE: begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_pend  = 1'b0;
                            n_state = S_PURGE;
                        end
                    end
                    default: begin
                        n_res_st = ST_OK;
                    end
                endcase
            end
            S_READ: begin
                n_res_dat = DATA_W'(w_q);
                if (r_act == ACT_POP) begin
                    n_count = w_top;
                end
                n_state = S_DONE;
            end
            S_PURGE: begin
                // Reads run one entry ahead of the compare; the write pointer
                // never passes the read pointer, so compaction is in place.
                n_pend = w_issue;
                if (w_issue) begin
                    w_re    = 1'b1;
                    w_raddr = r_rd[AW-1:0];
                    n_rd    = CW'(r_rd + 1'b1);
                end
                if (r_pend && (w_q != r_word)) begin
                    w_we    = 1'b1;
                    w_waddr = r_wr[AW-1:0];
                    w_wdata = w_q;
                    n_wr    = CW'(r_wr + 1'b1);
                end
                if (!w_issue && !r_pend) begin
                    if (r_wr == r_count) begin
                        n_res_st = ST_NOTFOUND;
                    end else begin
                        n_res_st = ST_OK;
                        n_count  = r_wr;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_st;
                    n_o_data    = r_res_dat;
                    n_o_depth   = DEPTH_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_word     <= n_word;
        r_res_st   <= n_res_st;
        r_res_dat  <= n_res_dat;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_depth  <= n_o_depth;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_o_status;
    assign o_data   = r_o_data;
    assign o_depth  = r_o_depth;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds the stack depth");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PURGE) |-> (r_wr <= r_rd) && (r_rd <= r_count))
        else $error("purge write pointer passed the read pointer");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EXEC))
        else $error("accepted request did not start execution");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !(r_out_valid && i_stall) |=> o_valid && (r_state == S_IDLE))
        else $error("finished request did not produce a result");

endmodule
